[hdl/isq_pkg.sv]
package isq_pkg;

    // Request codes; code seven is unused and reports an invalid position
    typedef enum logic [2:0] {
        OP_INS_POS   = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_INS_BACK  = 3'd2,
        OP_READ      = 3'd3,
        OP_DEL_POS   = 3'd4,
        OP_DEL_FRONT = 3'd5,
        OP_DEL_BACK  = 3'd6
    } opcode_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam int unsigned POS_W   = 5;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    localparam logic signed [VALUE_W-1:0] READ_FAIL_VALUE = -32'sd1;

    // Per-cell command for one cycle
    typedef struct packed {
        logic load;
        logic from_left;
        logic from_right;
    } cell_ctl_t;

endpackage

[hdl/indexed_sequence_store.sv]
// Ordered store of up to CAPACITY signed 32-bit words, held in a row of cells that shift
// up on an insert and down on a delete. A request is taken on any cycle with start high
// (busy stays low), so a new request may follow every cycle; its result appears on the
// next cycle for exactly one cycle, marked by done, and must be captured then because the
// receiver cannot hold it. Each request is carried out by the single load multiplexer in
// each cell and the position compare that drives it. entry_count gives the
// count after the request, taken modulo 32. Positions beyond 31 cannot be named.
module indexed_sequence_store
    import isq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 opcode,
    input  logic [POS_W-1:0]           position,
    input  logic signed [VALUE_W-1:0]  item_value,
    output logic                       done,
    output logic [1:0]                 status,
    output logic signed [VALUE_W-1:0]  read_value,
    output logic [COUNT_W-1:0]         entry_count
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      done_reg;
    logic                      done_next;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;
    logic signed [VALUE_W-1:0] read_value_reg;
    logic signed [VALUE_W-1:0] read_value_next;
    logic [COUNT_W-1:0]        entry_count_reg;
    logic [COUNT_W-1:0]        entry_count_next;

    logic [CMP_W-1:0]          cnt_ext;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          eff_pos;
    logic [CMP_W-1:0]          next_cnt_ext;
    logic                      ins_ok;
    logic                      del_ok;
    logic signed [VALUE_W-1:0] read_word;

    cell_ctl_t                 cell_ctl   [CAPACITY];
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];

    assign busy    = 1'b0;
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(position);

    // Pick the position the request works on
    always_comb
    begin
        case (opcode)
            OP_INS_FRONT, OP_DEL_FRONT:
            begin
                eff_pos = '0;
            end
            OP_INS_BACK:
            begin
                eff_pos = cnt_ext;
            end
            OP_DEL_BACK:
            begin
                eff_pos = cnt_ext - CMP_W'(1);
            end
            default:
            begin
                eff_pos = pos_ext;
            end
        endcase
    end

    assign read_word = cell_value[eff_pos[IDX_W-1:0]];

    always_comb
    begin
        ins_ok          = 1'b0;
        del_ok          = 1'b0;
        status_next     = ST_INVALID;
        read_value_next = '0;
        case (opcode)
            OP_INS_POS, OP_INS_FRONT, OP_INS_BACK:
            begin
                if (eff_pos > cnt_ext)
                begin
                    status_next = ST_INVALID;
                end
                else if (cnt_ext == CMP_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    ins_ok      = 1'b1;
                end
            end
            OP_READ:
            begin
                if (eff_pos < cnt_ext)
                begin
                    status_next     = ST_OK;
                    read_value_next = read_word;
                end
                else
                begin
                    status_next     = ST_INVALID;
                    read_value_next = READ_FAIL_VALUE;
                end
            end
            OP_DEL_POS, OP_DEL_FRONT, OP_DEL_BACK:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (eff_pos >= cnt_ext)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    status_next = ST_OK;
                    del_ok      = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (start && ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (start && del_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign next_cnt_ext     = CMP_W'(count_next);
    assign entry_count_next = next_cnt_ext[COUNT_W-1:0];
    assign done_next        = start;

    // Cells above the insert point take their left neighbour; from the delete point on,
    // take the right neighbour
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_word;
        logic signed [VALUE_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_inner_left
            assign left_word = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_word = cell_value[i];
        end
        else
        begin : g_inner_right
            assign right_word = cell_value[i+1];
        end

        assign cell_ctl[i].load       = start && ins_ok && (CMP_W'(i) == eff_pos);
        assign cell_ctl[i].from_left  = start && ins_ok && (CMP_W'(i) > eff_pos);
        assign cell_ctl[i].from_right = start && del_ok && (CMP_W'(i) >= eff_pos);

        isq_cell u_cell
        (
            .clk         (clk),
            .ctl         (cell_ctl[i]),
            .new_value   (item_value),
            .left_value  (left_word),
            .right_value (right_word),
            .value       (cell_value[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        read_value_reg  <= read_value_next;
        entry_count_reg <= entry_count_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("accepted request gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done)
        else $error("result without a request");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && ins_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the store");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full reported while not full");
`endif

endmodule

[hdl/isq_cell.sv]
module isq_cell
    import isq_pkg::*;
(
    input  logic                       clk,
    input  cell_ctl_t                  ctl,
    input  logic signed [VALUE_W-1:0]  new_value,
    input  logic signed [VALUE_W-1:0]  left_value,
    input  logic signed [VALUE_W-1:0]  right_value,
    output logic signed [VALUE_W-1:0]  value
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            value_next = new_value;
        end
        else if (ctl.from_left)
        begin
            value_next = left_value;
        end
        else if (ctl.from_right)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
